// ===== rtl/nfsa_pkg.sv =====
// Shared types and constants of the next-fit slot allocator.
package nfsa_pkg;

   // Slots held by one cell of the chain.
   localparam int GROUP_SLOTS = 8;
   localparam int GROUP_BITS  = 3;

   // Broadcast command to the cell row.
   typedef enum logic [1:0] {
      CELL_NOP       = 2'd0,
      CELL_CLEAR_ALL = 2'd1,
      CELL_SET       = 2'd2,
      CELL_CLEAR     = 2'd3
   } cell_op_type;

   // Control group from the sequencer to every cell.
   typedef struct packed {
      cell_op_type op;
      logic        inject;
   } cell_ctl_type;

endpackage

// ===== rtl/nfsa_cell.sv =====
// One cell of the slot chain: a group of in-use bits and the scan token.
module nfsa_cell
   import nfsa_pkg::*;
#(
   parameter int CELL_IDX = 0,
   parameter int IDXW     = 6,
   parameter int CW       = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctl_type      ctl,
   input  logic [IDXW-1:0]   cmd_idx,
   input  logic [CW-1:0]     win_lo,
   input  logic [CW-1:0]     win_hi,
   input  logic              tok_in,
   output logic              tok_out,
   output logic              hit,
   output logic              last,
   output logic [IDXW-1:0]   gnt,
   output logic              rel_busy
);

   localparam int BASE = CELL_IDX * GROUP_SLOTS;
   localparam int TOP  = BASE + GROUP_SLOTS;

   logic [GROUP_SLOTS-1:0] busy_ff, busy_in;
   logic                   tok_ff, tok_next_in;
   logic [GROUP_SLOTS-1:0] free_vec;
   logic [GROUP_BITS-1:0]  off;
   logic                   mine;
   logic [GROUP_BITS-1:0]  cmd_off;

   // Decode which cell the broadcast index falls in
   assign mine    = (int'(cmd_idx) >> GROUP_BITS) == CELL_IDX;
   assign cmd_off = GROUP_BITS'(int'(cmd_idx) & (GROUP_SLOTS - 1));

   // Free slots inside the search window
   always_comb begin
      for (int k = 0; k < GROUP_SLOTS; k++) begin
         free_vec[k] = !busy_ff[k] && (BASE + k >= int'(win_lo)) && (BASE + k < int'(win_hi));
      end
   end

   // Pick the lowest free slot
   always_comb begin
      off = '0;
      for (int k = GROUP_SLOTS - 1; k >= 0; k--) begin
         if (free_vec[k]) begin
            off = GROUP_BITS'(k);
         end
      end
   end

   assign hit      = tok_ff && (|free_vec);
   assign last     = tok_ff && (TOP >= int'(win_hi));
   assign tok_out  = tok_ff && !hit && !last;
   assign gnt      = hit ? IDXW'(BASE + int'(off)) : '0;
   assign rel_busy = mine && busy_ff[cmd_off];

   // Next token: from the left neighbour or injected here
   assign tok_next_in = tok_in || (ctl.inject && mine);

   // Update the in-use bits
   always_comb begin
      busy_in = busy_ff;
      case (ctl.op)
         CELL_CLEAR_ALL: busy_in = '0;
         CELL_SET: begin
            if (mine) busy_in[cmd_off] = 1'b1;
         end
         CELL_CLEAR: begin
            if (mine) busy_in[cmd_off] = 1'b0;
         end
         default: ;
      endcase
      if (hit) begin
         busy_in[off] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
         tok_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         tok_ff  <= tok_next_in;
      end
   end

endmodule

// ===== rtl/next_fit_slot_allocator.sv =====
// Next-fit slot allocator: a row of cells holding in-use bits, scanned by a travelling token.
// Restart, release and unused modes pass through S_START and S_FINISH; the result is registered
// as S_FINISH is left. Allocate adds S_SCAN, where the token walks the cells of the search window,
// and S_GROW when the pool grows. One item at a time: the next request is taken from
// the cycle the result appears, later while an earlier result still waits for rsp_ready.
// Reset clears every in-use bit, the pool size, pointer and count; initial_slots is 10, grow_step 1.
module next_fit_slot_allocator
   import nfsa_pkg::*;
#(
   parameter int MAX_SLOTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [5:0] req_slot_to_free,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [5:0] rsp_granted_slot,
   output logic       rsp_pool_grew,
   output logic [6:0] rsp_slots_in_use,
   output logic [6:0] rsp_pool_size,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata
);

   localparam int IDXW      = $clog2(MAX_SLOTS);
   localparam int CW        = $clog2(MAX_SLOTS + 1);
   localparam int NUM_CELLS = (MAX_SLOTS + GROUP_SLOTS - 1) / GROUP_SLOTS;
   localparam int DEFAULT_SLOTS = 10;

   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_RESTART = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_BAD_SLOT = 2'd2;

   localparam logic CSR_INITIAL_SLOTS = 1'b0;
   localparam logic CSR_GROW_STEP     = 1'b1;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_START  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_GROW   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0]      state_ff, state_in;
   logic [1:0]      mode_ff;
   logic [5:0]      slot_ff;
   logic [6:0]      initial_ff;
   logic [6:0]      step_ff;
   logic [CW-1:0]   active_ff, active_in;
   logic [IDXW-1:0] scan_ff, scan_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [IDXW-1:0] ptr0_ff, ptr0_in;
   logic            pass_ff, pass_in;
   logic [1:0]      res_status_ff, res_status_in;
   logic [IDXW-1:0] res_granted_ff, res_granted_in;
   logic            res_grew_ff, res_grew_in;
   logic            rsp_valid_ff;
   logic [1:0]      rsp_status_ff;
   logic [5:0]      rsp_granted_ff;
   logic            rsp_grew_ff;
   logic [6:0]      rsp_in_use_ff;
   logic [6:0]      rsp_size_ff;

   cell_ctl_type    ctl;
   logic [IDXW-1:0] cmd_idx;
   logic [CW-1:0]   win_lo, win_hi;
   logic            tok_out [NUM_CELLS];
   logic            hit     [NUM_CELLS];
   logic            last    [NUM_CELLS];
   logic [IDXW-1:0] gnt     [NUM_CELLS];
   logic            rel_busy[NUM_CELLS];
   logic            hit_any, last_any, rel_any;
   logic [IDXW-1:0] gnt_any;

   logic            accept, out_free;
   logic [IDXW-1:0] ptr_start;
   logic [CW-1:0]   restart_size, grow_size;
   int              init_sel, step_sel, grow_sum, gnt_next, grow_next;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // Search window of the current pass
   assign win_lo = pass_ff ? '0 : CW'(ptr0_ff);
   assign win_hi = pass_ff ? CW'(ptr0_ff) : active_ff;

   // Cell row
   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      nfsa_cell #(
         .CELL_IDX (i),
         .IDXW     (IDXW),
         .CW       (CW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .cmd_idx  (cmd_idx),
         .win_lo   (win_lo),
         .win_hi   (win_hi),
         .tok_in   ((i == 0) ? 1'b0 : tok_out[(i == 0) ? 0 : i - 1]),
         .tok_out  (tok_out[i]),
         .hit      (hit[i]),
         .last     (last[i]),
         .gnt      (gnt[i]),
         .rel_busy (rel_busy[i])
      );
   end

   // Gather the reports of the token holder
   always_comb begin
      hit_any  = 1'b0;
      last_any = 1'b0;
      rel_any  = 1'b0;
      gnt_any  = '0;
      for (int i = 0; i < NUM_CELLS; i++) begin
         hit_any  = hit_any | hit[i];
         last_any = last_any | last[i];
         rel_any  = rel_any | rel_busy[i];
         gnt_any  = gnt_any | gnt[i];
      end
   end

   // Size and pointer arithmetic
   always_comb begin
      init_sel     = (int'(initial_ff) > 1) ? int'(initial_ff) : DEFAULT_SLOTS;
      restart_size = (init_sel > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(init_sel);
      step_sel     = (step_ff != '0) ? int'(step_ff) : 1;
      grow_sum     = int'(active_ff) + step_sel;
      grow_size    = (grow_sum > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(grow_sum);
      grow_next    = int'(active_ff) + 1;
      gnt_next     = int'(gnt_any) + 1;
      ptr_start    = (int'(scan_ff) < int'(active_ff)) ? scan_ff : '0;
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      scan_in        = scan_ff;
      count_in       = count_ff;
      ptr0_in        = ptr0_ff;
      pass_in        = pass_ff;
      res_status_in  = res_status_ff;
      res_granted_in = res_granted_ff;
      res_grew_in    = res_grew_ff;
      ctl.op         = CELL_NOP;
      ctl.inject     = 1'b0;
      cmd_idx        = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_START;
         end
         S_START: begin
            res_status_in  = ST_OK;
            res_granted_in = '0;
            res_grew_in    = 1'b0;
            state_in       = S_FINISH;
            case (mode_ff)
               MODE_RESTART: begin
                  ctl.op    = CELL_CLEAR_ALL;
                  active_in = restart_size;
                  scan_in   = '0;
                  count_in  = '0;
               end
               MODE_RELEASE: begin
                  if (int'(slot_ff) < int'(active_ff)) begin
                     ctl.op   = CELL_CLEAR;
                     cmd_idx  = IDXW'(slot_ff);
                     count_in = count_ff - CW'(rel_any);
                  end else begin
                     res_status_in = ST_BAD_SLOT;
                  end
               end
               MODE_ALLOC: begin
                  if (active_ff == '0) begin
                     state_in = S_GROW;
                  end else begin
                     ctl.inject = 1'b1;
                     cmd_idx    = ptr_start;
                     ptr0_in    = ptr_start;
                     pass_in    = 1'b0;
                     state_in   = S_SCAN;
                  end
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            if (hit_any) begin
               res_granted_in = gnt_any;
               count_in       = count_ff + CW'(1);
               scan_in        = (gnt_next >= int'(active_ff)) ? '0 : IDXW'(gnt_next);
               state_in       = S_FINISH;
            end else if (last_any) begin
               if (!pass_ff && ptr0_ff != '0) begin
                  // Wrap to slot 0 for the second pass
                  ctl.inject = 1'b1;
                  cmd_idx    = '0;
                  pass_in    = 1'b1;
               end else if (int'(active_ff) >= MAX_SLOTS) begin
                  res_status_in = ST_FULL;
                  state_in      = S_FINISH;
               end else begin
                  state_in = S_GROW;
               end
            end
         end
         S_GROW: begin
            // Grant the first new slot
            ctl.op         = CELL_SET;
            cmd_idx        = IDXW'(active_ff);
            active_in      = grow_size;
            scan_in        = (grow_next >= int'(grow_size)) ? '0 : IDXW'(grow_next);
            count_in       = count_ff + CW'(1);
            res_granted_in = IDXW'(active_ff);
            res_grew_in    = 1'b1;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         scan_ff      <= '0;
         count_ff     <= '0;
         pass_ff      <= 1'b0;
         initial_ff   <= 7'(DEFAULT_SLOTS);
         step_ff      <= 7'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         active_ff <= active_in;
         scan_ff   <= scan_in;
         count_ff  <= count_in;
         pass_ff   <= pass_in;
         if (csr_we) begin
            case (csr_index)
               CSR_INITIAL_SLOTS: initial_ff <= csr_wdata;
               CSR_GROW_STEP:     step_ff    <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == S_FINISH && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr0_ff        <= ptr0_in;
      res_status_ff  <= res_status_in;
      res_granted_ff <= res_granted_in;
      res_grew_ff    <= res_grew_in;
      if (accept) begin
         mode_ff <= req_mode;
         slot_ff <= req_slot_to_free;
      end
      if (state_ff == S_FINISH && out_free) begin
         rsp_status_ff  <= res_status_ff;
         rsp_granted_ff <= 6'(res_granted_ff);
         rsp_grew_ff    <= res_grew_ff;
         rsp_in_use_ff  <= 7'(count_ff);
         rsp_size_ff    <= 7'(active_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_granted_ff;
   assign rsp_pool_grew    = rsp_grew_ff;
   assign rsp_slots_in_use = rsp_in_use_ff;
   assign rsp_pool_size    = rsp_size_ff;

endmodule

// ===== tb/sv/slot_grant_checker.sv =====
// Shared testbench codes and the checker that predicts and compares the slot allocator's responses.
package slot_alloc_tb_pkg;

   // Request modes of the input channel.
   typedef enum logic [1:0] {
      MODE_ALLOCATE = 2'd0,
      MODE_RELEASE  = 2'd1,
      MODE_RESTART  = 2'd2,
      MODE_UNUSED   = 2'd3
   } alloc_mode_type;

   // Response status codes.
   typedef enum logic [1:0] {
      GRANT_OK        = 2'd0,
      GRANT_POOL_FULL = 2'd1,
      GRANT_BAD_SLOT  = 2'd2
   } grant_status_type;

   // Configuration register indexes.
   localparam logic REG_INITIAL_SLOTS = 1'b0;
   localparam logic REG_GROW_STEP     = 1'b1;

   // Pool size used when the configured initial size is one or less.
   localparam int DEFAULT_POOL_SLOTS = 10;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] granted_slot;
      logic       pool_grew;
      logic [6:0] slots_in_use;
      logic [6:0] pool_size;
   } grant_result_type;

endpackage

module slot_grant_checker
   import slot_alloc_tb_pkg::*;
#(
   parameter int MAX_SLOTS = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [1:0] req_mode,
   input  logic [5:0] req_slot_to_free,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [1:0] rsp_status,
   input  logic [5:0] rsp_granted_slot,
   input  logic       rsp_pool_grew,
   input  logic [6:0] rsp_slots_in_use,
   input  logic [6:0] rsp_pool_size,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata,
   output int         error_count,
   output int         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow of the allocator state and its registers.
   logic [MAX_SLOTS-1:0] busy_map;
   int unsigned          pool_slots;
   int unsigned          scan_ptr;
   int unsigned          cfg_initial;
   int unsigned          cfg_step;

   grant_result_type expected_grants[$];
   grant_result_type observed;
   grant_result_type wanted;
   grant_result_type predicted;

   initial begin
      error_count = 0;
      pending     = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns slot allocator mismatch: %s", $time, msg);
      error_count++;
   endtask

   task automatic compare_field(input string field, input int unsigned got,
                                input int unsigned want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
      end
   endtask

   function automatic int unsigned count_in_use();
      int unsigned n;
      n = 0;
      for (int unsigned i = 0; i < pool_slots; i++) begin
         n += busy_map[i];
      end
      return n;
   endfunction

   // Apply one request to the shadow state and work out its response.
   task automatic predict_grant(input logic [1:0] mode, input logic [5:0] slot,
                                output grant_result_type r);
      int unsigned ptr;
      int unsigned probe;
      int unsigned step;
      int unsigned old_size;
      int unsigned new_size;
      bit          found;
      r = '0;
      r.status = GRANT_OK;
      case (mode)
         MODE_RESTART: begin
            new_size = (cfg_initial > 1) ? cfg_initial : DEFAULT_POOL_SLOTS;
            if (new_size > MAX_SLOTS) new_size = MAX_SLOTS;
            busy_map   = '0;
            pool_slots = new_size;
            scan_ptr   = 0;
         end
         MODE_RELEASE: begin
            if (slot >= pool_slots) begin
               r.status = GRANT_BAD_SLOT;
            end else begin
               busy_map[slot] = 1'b0;
            end
         end
         MODE_ALLOCATE: begin
            // Next-fit scan from the rotating pointer, wrapping at the pool size
            found = 1'b0;
            ptr   = (scan_ptr < pool_slots) ? scan_ptr : 0;
            for (probe = 0; probe < pool_slots && !found; probe++) begin
               if (!busy_map[ptr]) begin
                  busy_map[ptr]  = 1'b1;
                  r.granted_slot = 6'(ptr);
                  found          = 1'b1;
               end
               ptr++;
               if (ptr >= pool_slots) ptr = 0;
            end
            if (found) begin
               scan_ptr = ptr;
            end else if (pool_slots >= MAX_SLOTS) begin
               r.status = GRANT_POOL_FULL;
            end else begin
               // Grow the pool and hand out its first new slot
               step     = (cfg_step > 0) ? cfg_step : 1;
               old_size = pool_slots;
               new_size = old_size + step;
               if (new_size > MAX_SLOTS) new_size = MAX_SLOTS;
               pool_slots         = new_size;
               busy_map[old_size] = 1'b1;
               r.granted_slot     = 6'(old_size);
               r.pool_grew        = 1'b1;
               scan_ptr           = (old_size + 1 >= new_size) ? 0 : old_size + 1;
            end
         end
         default: begin
         end
      endcase
      r.slots_in_use = 7'(count_in_use());
      r.pool_size    = 7'(pool_slots);
   endtask

   // Compare responses first, then take register writes and new requests
   always @(posedge clock) begin
      if (reset) begin
         busy_map    = '0;
         pool_slots  = 0;
         scan_ptr    = 0;
         cfg_initial = DEFAULT_POOL_SLOTS;
         cfg_step    = 1;
         expected_grants.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            observed = '{rsp_status, rsp_granted_slot, rsp_pool_grew,
                         rsp_slots_in_use, rsp_pool_size};
            if (expected_grants.size() == 0) begin
               report_mismatch($sformatf("response transfer with nothing outstanding: %p",
                                         observed));
            end else begin
               wanted = expected_grants.pop_front();
               compare_field("status", observed.status, wanted.status);
               compare_field("granted_slot", observed.granted_slot, wanted.granted_slot);
               compare_field("pool_grew", observed.pool_grew, wanted.pool_grew);
               compare_field("slots_in_use", observed.slots_in_use, wanted.slots_in_use);
               compare_field("pool_size", observed.pool_size, wanted.pool_size);
            end
         end
         if (csr_we) begin
            if (csr_index == REG_INITIAL_SLOTS) begin
               cfg_initial = 32'(csr_wdata);
            end else begin
               cfg_step = 32'(csr_wdata);
            end
         end
         if (req_valid && req_ready) begin
            predict_grant(req_mode, req_slot_to_free, predicted);
            expected_grants.push_back(predicted);
         end
      end
      pending <= expected_grants.size();
   end

endmodule

// ===== tb/sv/next_fit_slot_allocator_tb.sv =====
// Testbench top of the next-fit slot allocator: clock, reset, stimulus, response pacing, verdict.
module next_fit_slot_allocator_tb;
   import slot_alloc_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL_CAP     = 64;
   localparam int RANDOM_ITEMS = 1100;
   localparam int DIRECTED_ITEMS = 25;
   localparam int CYCLE_LIMIT  = 600000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_mode = MODE_UNUSED;
   logic [5:0] req_slot_to_free = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [5:0] rsp_granted_slot;
   logic       rsp_pool_grew;
   logic [6:0] rsp_slots_in_use;
   logic [6:0] rsp_pool_size;
   logic       csr_we = 1'b0;
   logic       csr_index = REG_INITIAL_SLOTS;
   logic [6:0] csr_wdata = '0;

   int          error_count;
   int          pending;
   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   int unsigned cycle_count = 0;

   next_fit_slot_allocator #(
      .MAX_SLOTS(POOL_CAP)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_slot_to_free(req_slot_to_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_granted_slot(rsp_granted_slot),
      .rsp_pool_grew   (rsp_pool_grew),
      .rsp_slots_in_use(rsp_slots_in_use),
      .rsp_pool_size   (rsp_pool_size),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   slot_grant_checker #(
      .MAX_SLOTS(POOL_CAP)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_slot_to_free(req_slot_to_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_granted_slot(rsp_granted_slot),
      .rsp_pool_grew   (rsp_pool_grew),
      .rsp_slots_in_use(rsp_slots_in_use),
      .rsp_pool_size   (rsp_pool_size),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .error_count     (error_count),
      .pending         (pending)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog: end the run if it hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Offer one request, hold it until the transfer, then keep the burst going or pause
   task automatic send_item(input alloc_mode_type mode, input logic [5:0] slot);
      req_mode         <= mode;
      req_slot_to_free <= slot;
      req_valid        <= 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
      end else begin
         burst_left--;
      end
   endtask

   // Stop offering and wait for every outstanding response
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_config(input logic [6:0] initial_slots, input logic [6:0] grow_step);
      drain_block();
      csr_we    <= 1'b1;
      csr_index <= REG_INITIAL_SLOTS;
      csr_wdata <= initial_slots;
      @(posedge clock);
      csr_index <= REG_GROW_STEP;
      csr_wdata <= grow_step;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Restart, allocate until the pool is at capacity, then churn holes and hit the full case
   task automatic run_fill_phase();
      int unsigned k;
      send_item(MODE_RESTART, 6'($urandom()));
      for (k = 0; k < POOL_CAP + 2; k++) begin
         send_item(MODE_ALLOCATE, 6'($urandom()));
      end
      for (k = 0; k < 16; k++) begin
         if ($urandom_range(0, 1)) begin
            send_item(MODE_RELEASE, 6'($urandom()));
         end else begin
            send_item(MODE_ALLOCATE, 6'($urandom()));
         end
      end
   endtask

   // Random mix of modes, releases mostly aimed at the low slots
   task automatic run_mixed_phase();
      int unsigned k;
      int unsigned n;
      int unsigned pick;
      logic [5:0]  slot;
      n = $urandom_range(20, 60);
      if ($urandom_range(0, 1)) send_item(MODE_RESTART, 6'($urandom()));
      for (k = 0; k < n; k++) begin
         pick = $urandom_range(0, 19);
         slot = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                           : 6'($urandom_range(0, 15));
         if (pick < 10) begin
            send_item(MODE_ALLOCATE, 6'($urandom()));
         end else if (pick < 16) begin
            send_item(MODE_RELEASE, slot);
         end else if (pick < 18) begin
            send_item(MODE_RESTART, slot);
         end else begin
            send_item(MODE_UNUSED, slot);
         end
      end
   endtask

   // Response pacing: random stall patterns plus one long hold-off to back the block up
   initial begin : rsp_pacing
      int unsigned style;
      int unsigned seg;
      bit          held_off;
      held_off = 1'b0;
      @(posedge clock);
      forever begin
         if (!held_off && items_sent >= 250) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            style = $urandom_range(0, 3);
            seg   = $urandom_range(10, 60);
            repeat (seg) begin
               case (style)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= 1'b0;
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      logic [6:0] init_val;
      logic [6:0] step_val;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pool before any restart, growth from zero, bad and idle releases
      send_item(MODE_RELEASE, 6'd0);
      send_item(MODE_ALLOCATE, 6'd63);
      send_item(MODE_ALLOCATE, 6'd0);
      send_item(MODE_RELEASE, 6'd0);
      send_item(MODE_ALLOCATE, 6'd0);
      send_item(MODE_UNUSED, 6'd63);
      send_item(MODE_RESTART, 6'd0);
      send_item(MODE_RELEASE, 6'd63);
      send_item(MODE_RELEASE, 6'd9);
      send_item(MODE_ALLOCATE, 6'd0);
      send_item(MODE_ALLOCATE, 6'd0);
      send_item(MODE_ALLOCATE, 6'd0);
      send_item(MODE_RELEASE, 6'd1);

      // Initial size of one and zero step both fall back to their defaults
      write_config(7'd1, 7'd0);
      send_item(MODE_RESTART, 6'd0);
      send_item(MODE_ALLOCATE, 6'd0);

      // Oversized initial size saturates at the capacity
      write_config(7'd127, 7'd127);
      send_item(MODE_RESTART, 6'd0);
      send_item(MODE_ALLOCATE, 6'd0);
      send_item(MODE_RELEASE, 6'd63);
      send_item(MODE_RELEASE, 6'd0);

      // Tiny pool with a large step: growth saturates at the capacity
      write_config(7'd2, 7'd64);
      send_item(MODE_RESTART, 6'd0);
      send_item(MODE_ALLOCATE, 6'd0);
      send_item(MODE_ALLOCATE, 6'd0);
      send_item(MODE_ALLOCATE, 6'd0);
      send_item(MODE_RELEASE, 6'd2);
      send_item(MODE_ALLOCATE, 6'd0);

      // Random phases, each optionally under a new register setting
      while (items_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
               0:       init_val = 7'd0;
               1:       init_val = 7'd1;
               2:       init_val = 7'd2;
               3:       init_val = 7'd64;
               4:       init_val = 7'd127;
               5:       init_val = 7'($urandom_range(65, 126));
               default: init_val = 7'($urandom_range(3, 20));
            endcase
            case ($urandom_range(0, 6))
               0:       step_val = 7'd0;
               1:       step_val = 7'd1;
               2:       step_val = 7'd64;
               3:       step_val = 7'd127;
               default: step_val = 7'($urandom_range(2, 12));
            endcase
            write_config(init_val, step_val);
         end
         if ($urandom_range(0, 4) == 0) begin
            run_fill_phase();
         end else begin
            run_mixed_phase();
         end
      end

      // Wait out every response, then a margin for the block's latency
      drain_block();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
